// ===== hdl/slcs_pkg.sv =====
// Shared types and constants for the scan-line lane centre steering block.
// No dependencies.
package slcs_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_THRESHOLD  = 3'd0;
   localparam logic [2:0] CSR_LINE_WIDTH = 3'd1;
   localparam logic [2:0] CSR_GAIN       = 3'd2;
   localparam logic [2:0] CSR_BASE_SPEED = 3'd3;
   localparam logic [2:0] CSR_FAST_SPEED = 3'd4;
   localparam logic [2:0] CSR_BAND_LOW   = 3'd5;
   localparam logic [2:0] CSR_BAND_HIGH  = 3'd6;

   // Register reset values
   localparam logic [7:0]  THRESHOLD_RST = 8'd150;
   localparam int          WIDTH_RST     = 640;
   localparam logic [11:0] GAIN_RST      = 12'd512;
   localparam logic [15:0] BASE_RST      = 16'd3277;
   localparam logic [15:0] FAST_RST      = 16'd13107;
   localparam logic [15:0] BAND_LOW_RST  = 16'd30802;
   localparam logic [15:0] BAND_HIGH_RST = 16'd34734;

   localparam int LINE_WIDTH_W = 13;
   localparam int MIN_WIDTH    = 8;

   // x/5 == (x * 52429) >> 18 for every x below 2^16
   localparam logic [15:0] DIV5_MUL   = 16'd52429;
   localparam int          DIV5_SHIFT = 18;

   localparam logic [16:0] HALF_Q16 = 17'd32768;
   localparam int          TURN_MAX = 524287;
   localparam int          TURN_MIN = -524288;

   typedef enum logic [2:0] {
      ST_PIXEL,
      ST_FETCH,
      ST_DIV,
      ST_STEER,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hdl/scanline_lane_center_steer_core.sv =====
// Top level of the scan-line lane centre steering block.
// Depends on slcs_pkg, slcs_ram, slcs_divider and slcs_steer.
//
// Usage:
//  req_ channel: one grayscale pixel per item, left to right, one per cycle
//  while a line is being received. Bright columns inside the middle window
//  are recorded in a candidate RAM.
//  rsp_ channel: one item per line, issued after the last pixel. tuser flags
//  whether any column qualified; otherwise speed and turn repeat the held
//  commands and the position is zero.
//  csr_ channel: register writes, always ready; write only while idle.
//  Sequence: after the last pixel of a line req_tready drops. A line with
//  candidates then goes through the RAM read, the divider (CW+16 quotient
//  bits, CW = clog2(MAX_WIDTH), 12 at 4096) and its done flag, the steering
//  stage and the output load; a line without candidates skips to the output.
//  Throughput: one pixel per cycle within a line.
//  The output register frees the input side: pixels of the next line are
//  taken while a result waits; a stalled receiver holds the block only when
//  another line ends before the waiting result is taken.
//  Reset: counters cleared, registers to their defaults, held speed 3277 and
//  held turn zero. RAM contents need no clearing.
module scanline_lane_center_steer_core
   import slcs_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // lane_position[15:0], speed[31:16], turn_rate[51:32]
   output logic        rsp_tuser,   // found[0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int XW = WW + 1;
   localparam int NUM_W = CW + 16;
   localparam int LW = LINE_WIDTH_W + 1;
   localparam int W_RST = (MAX_WIDTH < WIDTH_RST) ? MAX_WIDTH : WIDTH_RST;
   localparam int M_RST = W_RST / 5;

   state_type state_ff, state_in;

   logic [7:0]    thr_ff, thr_in;
   logic [11:0]   gain_ff, gain_in;
   logic [15:0]   base_ff, base_in;
   logic [15:0]   fast_ff, fast_in;
   logic [15:0]   band_lo_ff, band_lo_in;
   logic [15:0]   band_hi_ff, band_hi_in;
   logic [WW-1:0] eff_w_ff, eff_w_in;
   logic [WW-1:0] margin_ff, margin_in;
   logic [WW-1:0] win_end_ff, win_end_in;

   logic [LW-1:0] lw_clamp;
   logic [29:0]   div5_prod;
   logic [WW-1:0] new_margin;

   logic [CW-1:0] col_ff, col_in;
   logic [WW-1:0] total_ff, total_in;
   logic          found_ff, found_in;
   logic [15:0]   pos_ff, pos_in;

   logic [15:0]        held_speed_ff, held_speed_in;
   logic signed [19:0] held_turn_ff, held_turn_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [15:0]        rsp_pos_ff, rsp_pos_in;
   logic [15:0]        rsp_speed_ff, rsp_speed_in;
   logic signed [19:0] rsp_turn_ff, rsp_turn_in;

   logic          accept;
   logic          px_hit;
   logic          line_end;
   logic [XW-1:0] col_x;
   logic          out_free;
   logic          out_load;
   logic          steer_calc;
   logic          div_start;

   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [CW-1:0] ram_rd_addr;
   logic [CW-1:0] ram_rd_data;

   logic [NUM_W-1:0]   quotient;
   div_status_type     div_status;
   logic [15:0]        pos_sat;
   logic [15:0]        steer_speed;
   logic signed [19:0] steer_turn;

   // Configuration
   assign csr_ready = 1'b1;

   always_comb begin
      lw_clamp = {1'b0, csr_wdata[LINE_WIDTH_W-1:0]};
      if (lw_clamp < LW'(MIN_WIDTH)) begin
         lw_clamp = LW'(MIN_WIDTH);
      end else if (lw_clamp > LW'(MAX_WIDTH)) begin
         lw_clamp = LW'(MAX_WIDTH);
      end
      div5_prod  = 30'(lw_clamp) * 30'(DIV5_MUL);
      new_margin = WW'(div5_prod >> DIV5_SHIFT);

      thr_in     = thr_ff;
      gain_in    = gain_ff;
      base_in    = base_ff;
      fast_in    = fast_ff;
      band_lo_in = band_lo_ff;
      band_hi_in = band_hi_ff;
      eff_w_in   = eff_w_ff;
      margin_in  = margin_ff;
      win_end_in = win_end_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD:  thr_in = csr_wdata[7:0];
            CSR_LINE_WIDTH: begin
               eff_w_in   = WW'(lw_clamp);
               margin_in  = new_margin;
               win_end_in = WW'(lw_clamp) - new_margin;
            end
            CSR_GAIN:       gain_in = csr_wdata[11:0];
            CSR_BASE_SPEED: base_in = csr_wdata;
            CSR_FAST_SPEED: fast_in = csr_wdata;
            CSR_BAND_LOW:   band_lo_in = csr_wdata;
            CSR_BAND_HIGH:  band_hi_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Pixel path
   assign accept = req_tvalid && req_tready;
   assign col_x  = XW'(col_ff);
   assign px_hit = (col_x >= XW'(margin_ff)) && (col_x < XW'(win_end_ff)) &&
                   (req_tdata > thr_ff) && (XW'(total_ff) < XW'(MAX_WIDTH));
   assign line_end = !((col_x + XW'(1)) < XW'(eff_w_ff));

   assign ram_wr_en   = accept && px_hit;
   assign ram_rd_en   = accept && line_end;
   assign ram_rd_addr = CW'(total_ff >> 1);

   assign pos_sat = (|quotient[NUM_W-1:16]) ? 16'hFFFF : quotient[15:0];
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      div_start  = 1'b0;
      steer_calc = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_PIXEL: begin
            req_tready = 1'b1;
            if (accept && line_end) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (found_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_STEER;
            end
         end
         ST_STEER: begin
            steer_calc = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_PIXEL;
            end
         end
         default: state_in = ST_PIXEL;
      endcase
   end

   always_comb begin
      col_in        = col_ff;
      total_in      = total_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      held_speed_in = held_speed_ff;
      held_turn_in  = held_turn_ff;
      if (accept) begin
         if (line_end) begin
            col_in   = '0;
            total_in = '0;
            found_in = (total_ff != '0);
            pos_in   = '0;
         end else begin
            col_in   = col_ff + CW'(1);
            total_in = total_ff + WW'(px_hit);
         end
      end
      if (div_status.done) begin
         pos_in = pos_sat;
      end

      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_turn_in  = rsp_turn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff;
         rsp_pos_in   = pos_ff;
         if (found_ff) begin
            rsp_speed_in  = steer_speed;
            rsp_turn_in   = steer_turn;
            held_speed_in = steer_speed;
            held_turn_in  = steer_turn;
         end else begin
            rsp_speed_in = held_speed_ff;
            rsp_turn_in  = held_turn_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_PIXEL;
         thr_ff        <= THRESHOLD_RST;
         gain_ff       <= GAIN_RST;
         base_ff       <= BASE_RST;
         fast_ff       <= FAST_RST;
         band_lo_ff    <= BAND_LOW_RST;
         band_hi_ff    <= BAND_HIGH_RST;
         eff_w_ff      <= WW'(W_RST);
         margin_ff     <= WW'(M_RST);
         win_end_ff    <= WW'(W_RST - M_RST);
         col_ff        <= '0;
         total_ff      <= '0;
         found_ff      <= 1'b0;
         held_speed_ff <= BASE_RST;
         held_turn_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         thr_ff        <= thr_in;
         gain_ff       <= gain_in;
         base_ff       <= base_in;
         fast_ff       <= fast_in;
         band_lo_ff    <= band_lo_in;
         band_hi_ff    <= band_hi_in;
         eff_w_ff      <= eff_w_in;
         margin_ff     <= margin_in;
         win_end_ff    <= win_end_in;
         col_ff        <= col_in;
         total_ff      <= total_in;
         found_ff      <= found_in;
         held_speed_ff <= held_speed_in;
         held_turn_ff  <= held_turn_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_turn_ff  <= rsp_turn_in;
   end

   slcs_ram #(
      .WIDTH(CW),
      .DEPTH(MAX_WIDTH)
   ) u_cand_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (CW'(total_ff)),
      .wr_data (col_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   slcs_divider #(
      .NUM_W(NUM_W),
      .DEN_W(WW)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   ({ram_rd_data, 16'h0000}),
      .denominator (eff_w_ff - WW'(1)),
      .quotient    (quotient),
      .status      (div_status)
   );

   slcs_steer u_steer (
      .clock      (clock),
      .calc       (steer_calc),
      .pos        (pos_ff),
      .gain       (gain_ff),
      .band_low   (band_lo_ff),
      .band_high  (band_hi_ff),
      .base_speed (base_ff),
      .fast_speed (fast_ff),
      .speed      (steer_speed),
      .turn       (steer_turn)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {4'h0, rsp_turn_ff, rsp_speed_ff, rsp_pos_ff};

   a_total_le_col: assert property (@(posedge clock) disable iff (reset)
      XW'(total_ff) <= col_x)
      else $error("more candidates than columns seen");

   a_fetch_after_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> $past(req_tvalid && req_tready))
      else $error("fetch state without a line end");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide state");

endmodule

// ===== hdl/slcs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module slcs_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/slcs_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on slcs_pkg.
module slcs_divider
   import slcs_pkg::*;
#(
   parameter int NUM_W = 28,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic [NUM_W-1:0] quotient,
   output div_status_type   status
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NUM_W-1:0] shift_ff, shift_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DEN_W:0]   rem_try;
   logic [DEN_W:0]   rem_diff;
   logic             fits;

   always_comb begin
      rem_try  = {rem_ff, shift_ff[NUM_W-1]};
      fits     = rem_try >= {1'b0, den_ff};
      rem_diff = rem_try - {1'b0, den_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      count_in = count_ff;
      if (start) begin
         busy_in  = 1'b1;
         shift_in = numerator;
         rem_in   = '0;
         den_in   = denominator;
         count_in = CNT_W'(NUM_W);
      end else if (busy_ff) begin
         shift_in = {shift_ff[NUM_W-2:0], fits};
         rem_in   = fits ? rem_diff[DEN_W-1:0] : rem_try[DEN_W-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      count_ff <= count_in;
   end

   assign quotient    = shift_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

// ===== hdl/slcs_steer.sv =====
// Speed selection and proportional turn command with saturation.
// Depends on slcs_pkg.
module slcs_steer
   import slcs_pkg::*;
(
   input  logic               clock,
   input  logic               calc,
   input  logic [15:0]        pos,
   input  logic [11:0]        gain,
   input  logic [15:0]        band_low,
   input  logic [15:0]        band_high,
   input  logic [15:0]        base_speed,
   input  logic [15:0]        fast_speed,
   output logic [15:0]        speed,
   output logic signed [19:0] turn
);

   localparam int PW = 30;
   localparam logic signed [PW-1:0] SAT_HI = PW'(TURN_MAX);
   localparam logic signed [PW-1:0] SAT_LO = PW'(TURN_MIN);

   logic signed [16:0]   err;
   logic signed [12:0]   gain_s;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [15:0]          speed_ff, speed_in;
   logic signed [PW-1:0] scaled;

   always_comb begin
      err      = $signed(HALF_Q16) - $signed({1'b0, pos});
      gain_s   = $signed({1'b0, gain});
      prod_in  = prod_ff;
      speed_in = speed_ff;
      if (calc) begin
         prod_in  = gain_s * err;
         speed_in = (pos >= band_low && pos <= band_high) ? fast_speed : base_speed;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      speed_ff <= speed_in;
   end

   // floor division by 256
   always_comb begin
      scaled = prod_ff >>> 8;
      if (scaled > SAT_HI) begin
         turn = SAT_HI[19:0];
      end else if (scaled < SAT_LO) begin
         turn = SAT_LO[19:0];
      end else begin
         turn = scaled[19:0];
      end
   end

   assign speed = speed_ff;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for scanline_lane_center_steer_core: feeds scan lines of pixels,
// predicts each end-of-line steering item and checks it field by field.
// Depends on slcs_pkg and the core RTL.
module tb
   import slcs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W         = 4096;
   localparam int SETTLE_CYCLES = 100;
   localparam int LONG_HOLD     = 300;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PIXELS = 400;
   localparam int MIN_PHASES    = 4;
   localparam int WIDE_PIXELS   = 830;
   localparam logic [2:0] CSR_SPARE = 3'd7;

   typedef enum {LINE_NOISE, LINE_DARK, LINE_BRIGHT, LINE_SPOT, LINE_EDGES} line_shape_type;
   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic               found;
      logic [15:0]        position;
      logic [15:0]        speed;
      logic signed [19:0] turn;
   } steer_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // register copies
   logic [7:0]  thr_cfg       = THRESHOLD_RST;
   logic [12:0] width_cfg     = 13'(WIDTH_RST);
   logic [11:0] gain_cfg      = GAIN_RST;
   logic [15:0] base_cfg      = BASE_RST;
   logic [15:0] fast_cfg      = FAST_RST;
   logic [15:0] band_low_cfg  = BAND_LOW_RST;
   logic [15:0] band_high_cfg = BAND_HIGH_RST;

   // line state
   logic [11:0]        col_count  = '0;
   int unsigned        cand_total = 0;
   logic [11:0]        cand_store [MAX_W];
   logic [15:0]        held_speed = BASE_RST;
   logic signed [19:0] held_turn  = '0;

   logic [7:0] pixel_q [$];
   steer_cmd_type cmd_expect_q [$];
   steer_cmd_type exp_cmd;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit long_hold_req  = 1'b0;
   bit long_hold_done = 1'b0;
   int hold_cycles    = 0;

   int fail_count    = 0;
   int pixels_taken  = 0;
   int lines_seen    = 0;
   int lanes_seen    = 0;
   int csr_writes    = 0;
   int random_pixels = 0;
   int cycle_count   = 0;
   int phase         = 0;

   scanline_lane_center_steer_core #(.MAX_WIDTH(MAX_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void queue_pixel(input logic [7:0] px);
      pixel_q.insert(pixel_q.size(), px);
   endfunction

   function automatic int unsigned eff_width();
      eff_width = width_cfg;
      if (eff_width < MIN_WIDTH) eff_width = MIN_WIDTH;
      if (eff_width > MAX_W) eff_width = MAX_W;
   endfunction

   // advance the line by one pixel; queue the steering item at end of line
   function automatic void take_pixel(input logic [7:0] px);
      int unsigned       w;
      int unsigned       margin;
      int unsigned       col;
      int unsigned       idx;
      longint unsigned   quot;
      longint            prod;
      longint            q;
      steer_cmd_type     cmd;
      w = eff_width();
      margin = w / 5;
      col = col_count;
      if (col >= margin && col < w - margin && px > thr_cfg && cand_total < MAX_W) begin
         cand_store[cand_total] = col[11:0];
         cand_total++;
      end
      if (col + 1 < w) begin
         col_count = 12'(col + 1);
         return;
      end
      cmd = '0;
      if (cand_total > 0) begin
         idx = cand_store[(cand_total / 2) % MAX_W];
         quot = idx;
         quot = (quot << 16) / (w - 1);
         if (quot > 65535) quot = 65535;
         held_speed = (quot >= band_low_cfg && quot <= band_high_cfg) ? fast_cfg : base_cfg;
         prod = longint'(gain_cfg) * (longint'(32768) - longint'(quot));
         q = prod >>> 8;
         if (q > TURN_MAX) q = TURN_MAX;
         if (q < TURN_MIN) q = TURN_MIN;
         held_turn = 20'(q);
         cmd.found = 1'b1;
         cmd.position = quot[15:0];
      end
      cmd.speed = held_speed;
      cmd.turn = held_turn;
      col_count = '0;
      cand_total = 0;
      cmd_expect_q.insert(cmd_expect_q.size(), cmd);
   endfunction

   function automatic void check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   function automatic logic [7:0] dim_pixel();
      dim_pixel = 8'($urandom_range(0, thr_cfg));
   endfunction

   function automatic logic [7:0] lit_pixel();
      lit_pixel = (thr_cfg == 8'd255) ? 8'd255 : 8'($urandom_range(thr_cfg + 1, 255));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pixel_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles == LONG_HOLD - 1) long_hold_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (cmd_expect_q.size() == 0) begin
               $display("%0t: unexpected item: found %0d position %0d speed %0d turn %0d",
                        $time, rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16],
                        $signed(rsp_tdata[51:32]));
               fail_count++;
            end else begin
               exp_cmd = cmd_expect_q.pop_front();
               check_field("found", exp_cmd.found, rsp_tuser);
               check_field("lane_position", exp_cmd.position, rsp_tdata[15:0]);
               check_field("speed", exp_cmd.speed, rsp_tdata[31:16]);
               check_field("turn_rate", longint'($signed(exp_cmd.turn)),
                           longint'($signed(rsp_tdata[51:32])));
               check_field("tdata padding", 0, rsp_tdata[55:52]);
               lines_seen++;
               if (exp_cmd.found) lanes_seen++;
            end
         end
         if (req_tvalid && req_tready) begin
            take_pixel(req_tdata);
            pixels_taken++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_THRESHOLD:  thr_cfg = val[7:0];
         CSR_LINE_WIDTH: width_cfg = val[12:0];
         CSR_GAIN:       gain_cfg = val[11:0];
         CSR_BASE_SPEED: base_cfg = val;
         CSR_FAST_SPEED: fast_cfg = val;
         CSR_BAND_LOW:   band_low_cfg = val;
         CSR_BAND_HIGH:  band_high_cfg = val;
         default: ;
      endcase
      csr_writes++;
   endtask

   // wait for every pixel taken and every item back, then let the core settle
   task automatic wait_idle();
      while (pixel_q.size() != 0 || req_tvalid || cmd_expect_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      @(negedge clock);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 70; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 70; end
         IDLE_BOTH:     begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
   endtask

   task automatic feed_lines(input int count, input bit count_random);
      line_shape_type shape;
      int unsigned n;
      int unsigned margin;
      int unsigned start;
      int unsigned len;
      logic [7:0]  px;
      @(negedge clock);
      repeat (count) begin
         n = eff_width();
         margin = n / 5;
         shape = line_shape_type'($urandom_range(0, 4));
         start = $urandom_range(0, n - 1);
         len = $urandom_range(1, n / 3 + 1);
         for (int unsigned c = 0; c < n; c++) begin
            case (shape)
               LINE_NOISE:  px = 8'($urandom_range(0, 255));
               LINE_DARK:   px = dim_pixel();
               LINE_BRIGHT: px = lit_pixel();
               LINE_SPOT:   px = (c >= start && c < start + len) ? lit_pixel() : dim_pixel();
               LINE_EDGES:  px = ((c == margin - 1 || c == margin || c == n - margin - 1 ||
                                   c == n - margin) && $urandom_range(0, 1) == 1) ?
                                  lit_pixel() : dim_pixel();
            endcase
            queue_pixel(px);
         end
         if (count_random) random_pixels += n;
      end
   endtask

   task automatic set_phase_config();
      int unsigned w;
      int unsigned r;
      logic [15:0] lo;
      logic [15:0] hi;
      r = $urandom_range(0, 5);
      write_reg(CSR_THRESHOLD, {8'($urandom), (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
                                              8'($urandom_range(60, 220))});
      r = $urandom_range(0, 9);
      w = (r == 0) ? $urandom_range(0, 7) : (r == 1) ? $urandom_range(41, 160) :
                                                       $urandom_range(8, 40);
      write_reg(CSR_LINE_WIDTH, {3'($urandom), 13'(w)});
      r = $urandom_range(0, 5);
      write_reg(CSR_GAIN, {4'($urandom), (r == 0) ? 12'd0 : (r == 1) ? 12'd4095 :
                                         12'($urandom)});
      write_reg(CSR_BASE_SPEED, ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom));
      write_reg(CSR_FAST_SPEED, ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom));
      case ($urandom_range(0, 3))
         0: begin
            lo = 16'h0000;
            hi = 16'hFFFF;
         end
         1: begin
            // inverted band
            lo = 16'(32768 + $urandom_range(1, 10000));
            hi = 16'(32768 - $urandom_range(0, 10000));
         end
         default: begin
            lo = 16'(32768 - $urandom_range(0, 12000));
            hi = 16'(32768 + $urandom_range(0, 12000));
         end
      endcase
      write_reg(CSR_BAND_LOW, lo);
      write_reg(CSR_BAND_HIGH, hi);
   endtask

   initial begin
      logic [7:0] first_line [8];
      first_line = '{8'd255, 8'd151, 8'd150, 8'd0, 8'd255, 8'd200, 8'd255, 8'd255};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // narrowest line, width below minimum; pixel equal to threshold, window edges
      write_reg(CSR_LINE_WIDTH, 16'd3);
      @(negedge clock);
      foreach (first_line[i]) queue_pixel(first_line[i]);
      // dark line: held commands repeat
      repeat (8) queue_pixel(8'd0);
      wait_idle();
      write_reg(CSR_SPARE, 16'hFFFF);

      // width cut mid-line, the next pixel closes the line
      write_reg(CSR_LINE_WIDTH, 16'd20);
      @(negedge clock);
      repeat (10) queue_pixel(8'd255);
      wait_idle();
      write_reg(CSR_LINE_WIDTH, 16'd8);
      @(negedge clock);
      queue_pixel(8'd255);
      wait_idle();

      // receiver holds off while lines keep coming
      set_idling(IDLE_NONE);
      long_hold_req = 1'b1;
      feed_lines(12, 1'b0);
      wait_idle();

      while (random_pixels < RANDOM_PIXELS || phase < MIN_PHASES) begin
         set_phase_config();
         set_idling(idle_mode_type'(phase % 4));
         feed_lines($urandom_range(2, 5), 1'b1);
         wait_idle();
         phase++;
      end

      // width above maximum: window opens at the clamped width's margin, then the
      // line is cut short so the position saturates
      set_idling(IDLE_BOTH);
      write_reg(CSR_THRESHOLD, 16'd100);
      write_reg(CSR_LINE_WIDTH, 16'd8191);
      @(negedge clock);
      repeat (WIDE_PIXELS) queue_pixel(8'd255);
      wait_idle();
      write_reg(CSR_LINE_WIDTH, 16'd8);
      @(negedge clock);
      queue_pixel(8'd255);
      wait_idle();

      $display("Covered %0d pixels in %0d lines (%0d with a lane) over %0d random phases",
               pixels_taken, lines_seen, lanes_seen, phase);
      $display("%0d register writes, widths from below minimum to above maximum", csr_writes);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
